// ===== design/lcom_pkg.sv =====
// Shared constants, types and codes of the lidar curvature / occlusion marker.
`timescale 1ns / 1ps

package lcom_pkg;

  // Window geometry
  localparam int unsigned HALF_WINDOW = 5;
  localparam int unsigned DELAY       = HALF_WINDOW + 1;
  localparam int unsigned WIN         = 2 * DELAY;
  localparam int unsigned MAX_POINTS  = 65536;

  localparam int unsigned CNT_W  = $clog2(MAX_POINTS);
  localparam int unsigned SLOT_W = $clog2(DELAY + 1);
  localparam int unsigned FAR_W  = $clog2(HALF_WINDOW + 1);

  // Field widths
  localparam int unsigned RANGE_W = 18;
  localparam int unsigned COL_W   = 11;
  localparam int unsigned INT_W   = 16;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned CURV_W  = 43;
  localparam int unsigned CLASS_W = 2;

  // Curvature arithmetic
  localparam int unsigned MAG_W = RANGE_W + $clog2(2 * HALF_WINDOW);
  localparam int unsigned SQ_W  = 2 * MAG_W;

  // Register widths and reset values
  localparam int unsigned OCC_W      = 16;
  localparam int unsigned GAP_W      = 11;
  localparam int unsigned RATIO_W    = 10;
  localparam int unsigned LANE_W     = 16;
  localparam int unsigned CONTRAST_W = 17;

  localparam logic [OCC_W-1:0]      OCC_RST      = OCC_W'(300);
  localparam logic [GAP_W-1:0]      GAP_RST      = GAP_W'(10);
  localparam logic [RATIO_W-1:0]    RATIO_RST    = RATIO_W'(20);
  localparam logic [LANE_W-1:0]     LANE_RST     = LANE_W'(600);
  localparam logic [CONTRAST_W-1:0] CONTRAST_RST = CONTRAST_W'(590);

  // Parallel beam test
  localparam int unsigned PROD_W   = RANGE_W + RATIO_W;
  localparam int unsigned PERMILLE = 1000;

  // APB
  localparam int unsigned NUM_REGS   = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = $clog2(4 * NUM_REGS);
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_OCC_DEPTH     = 0,
    REG_COL_GAP       = 1,
    REG_BEAM_RATIO    = 2,
    REG_LANE_INT      = 3,
    REG_LANE_CONTRAST = 4
  } cfg_reg_e;

  typedef enum logic [CLASS_W-1:0] {
    LANE_NONE    = 0,
    LANE_CORNER  = 1,
    LANE_SURFACE = 2
  } lane_class_e;

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic [COL_W-1:0]   column;
    logic [INT_W-1:0]   intensity;
    logic               rej;
  } slot_t;

  typedef struct packed {
    logic near;
    logic far;
    logic par;
  } mark_t;

  typedef struct packed {
    logic [OCC_W-1:0]      occ_depth;
    logic [GAP_W-1:0]      col_gap;
    logic [RATIO_W-1:0]    beam_ratio;
    logic [LANE_W-1:0]     lane_int;
    logic [CONTRAST_W-1:0] lane_contrast;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] idx;
    logic             inr;
    logic             last;
  } meta_t;

endpackage

// ===== design/lcom_point_if.sv =====
// Input point channel: valid/ready handshake with the point payload.
`timescale 1ns / 1ps

interface lcom_point_if;
  import lcom_pkg::*;

  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_mm;
  logic [COL_W-1:0]   column;
  logic [INT_W-1:0]   intensity_tenths;
  logic               end_of_cloud;

  modport source (output valid, output range_mm, output column, output intensity_tenths,
                  output end_of_cloud, input ready);
  modport sink   (input valid, input range_mm, input column, input intensity_tenths,
                  input end_of_cloud, output ready);
endinterface

// ===== design/lcom_result_if.sv =====
// Result channel: valid/ready handshake with the per-point result payload.
`timescale 1ns / 1ps

interface lcom_result_if;
  import lcom_pkg::*;

  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   point_index;
  logic [CURV_W-1:0]  curvature;
  logic               rejected;
  logic [CLASS_W-1:0] lane_class;
  logic               in_range;
  logic               last_out;

  modport source (output valid, output point_index, output curvature, output rejected,
                  output lane_class, output in_range, output last_out, input ready);
  modport sink   (input valid, input point_index, input curvature, input rejected,
                  input lane_class, input in_range, input last_out, output ready);
endinterface

// ===== design/lcom_cell.sv =====
// One window cell: holds a point and takes its upstream neighbour on each shift.
`timescale 1ns / 1ps

module lcom_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic            mark_i,
  input  lcom_pkg::slot_t up_i,
  output lcom_pkg::slot_t slot_o
);
  import lcom_pkg::*;

  slot_t slot_q, slot_d;

  // reject marks raised this shift merge into the incoming point
  always_comb begin
    slot_d     = up_i;
    slot_d.rej = up_i.rej | mark_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

// ===== design/lcom_edge.sv =====
// Occlusion edge and parallel beam tests between the newest point and its predecessors.
`timescale 1ns / 1ps

module lcom_edge (
  input  logic                         en_i,
  input  lcom_pkg::slot_t              prev_i,
  input  lcom_pkg::slot_t              prev2_i,
  input  logic [lcom_pkg::RANGE_W-1:0] new_range_i,
  input  logic [lcom_pkg::COL_W-1:0]   new_col_i,
  input  lcom_pkg::cfg_t               cfg_i,
  output lcom_pkg::mark_t              mark_o
);
  import lcom_pkg::*;

  logic [COL_W-1:0]   col_diff;
  logic               nbr;
  logic               is_drop;
  logic [RANGE_W-1:0] drop;
  logic [RANGE_W-1:0] rise;
  logic [RANGE_W-1:0] dist_new;
  logic [RANGE_W-1:0] dist_prev;
  logic [PROD_W-1:0]  lim;
  logic [PROD_W-1:0]  new_scaled;
  logic [PROD_W-1:0]  prev_scaled;

  always_comb begin
    col_diff = (new_col_i > prev_i.column) ? new_col_i - prev_i.column
                                           : prev_i.column - new_col_i;
    nbr      = col_diff < cfg_i.col_gap;

    is_drop  = prev_i.range_mm > new_range_i;
    drop     = prev_i.range_mm - new_range_i;
    rise     = new_range_i - prev_i.range_mm;
    dist_new = is_drop ? drop : rise;
    dist_prev = (prev2_i.range_mm > prev_i.range_mm) ? prev2_i.range_mm - prev_i.range_mm
                                                     : prev_i.range_mm - prev2_i.range_mm;

    // both range steps must exceed ratio/1000 of the centre range
    lim         = PROD_W'(cfg_i.beam_ratio) * PROD_W'(prev_i.range_mm);
    new_scaled  = PROD_W'(dist_new) * PROD_W'(PERMILLE);
    prev_scaled = PROD_W'(dist_prev) * PROD_W'(PERMILLE);

    mark_o.near = en_i && nbr && is_drop && (drop > RANGE_W'(cfg_i.occ_depth));
    mark_o.far  = en_i && nbr && !is_drop && (rise > RANGE_W'(cfg_i.occ_depth));
    mark_o.par  = en_i && (prev_scaled > lim) && (new_scaled > lim);
  end

endmodule

// ===== design/lcom_result_pipe.sv =====
// Result pipeline: window sums and lane class, magnitude, square and output register.
`timescale 1ns / 1ps

module lcom_result_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cap_valid_i,
  output logic            cap_ready_o,
  input  lcom_pkg::slot_t win_i [lcom_pkg::WIN],
  input  lcom_pkg::meta_t meta_i,
  input  lcom_pkg::cfg_t  cfg_i,
  lcom_result_if.source   result_o
);
  import lcom_pkg::*;

  localparam int unsigned EXT_W = (SQ_W > CURV_W) ? SQ_W : CURV_W;

  // capture
  logic [MAG_W-1:0]      pair_sum [HALF_WINDOW];
  logic [MAG_W-1:0]      nsum;
  logic [MAG_W-1:0]      csum;
  logic [INT_W:0]        twice;
  logic [INT_W:0]        sides;
  logic [INT_W:0]        lap;
  logic [CONTRAST_W-1:0] lap_ext;
  lane_class_e           cls;

  // stage a
  logic             a_valid_q;
  logic [MAG_W-1:0] a_nsum_q;
  logic [MAG_W-1:0] a_csum_q;
  meta_t            a_meta_q;
  logic             a_rej_q;
  lane_class_e      a_cls_q;

  // stage b
  logic             b_valid_q;
  logic [MAG_W-1:0] b_mag_q;
  meta_t            b_meta_q;
  logic             b_rej_q;
  lane_class_e      b_cls_q;

  // output register
  logic              c_valid_q;
  logic [CURV_W-1:0] c_curv_q;
  meta_t             c_meta_q;
  logic              c_rej_q;
  lane_class_e       c_cls_q;

  logic              adv_a, adv_b, adv_c;
  logic [SQ_W-1:0]   sq;
  logic [EXT_W-1:0]  sq_ext;
  logic [CURV_W-1:0] curv;

  assign adv_c       = !c_valid_q || result_o.ready;
  assign adv_b       = !b_valid_q || adv_c;
  assign adv_a       = !a_valid_q || adv_b;
  assign cap_ready_o = adv_a;

  always_comb begin
    for (int d = 0; d < HALF_WINDOW; d++) begin
      pair_sum[d] = MAG_W'(win_i[DELAY-1-d].range_mm) + MAG_W'(win_i[DELAY+1+d].range_mm);
    end
    nsum = '0;
    for (int d = 0; d < HALF_WINDOW; d++) begin
      nsum = nsum + pair_sum[d];
    end
    csum = MAG_W'(win_i[DELAY].range_mm) * MAG_W'(2 * HALF_WINDOW);

    // intensity second difference, absolute
    twice   = {win_i[DELAY].intensity, 1'b0};
    sides   = (INT_W + 1)'(win_i[DELAY-1].intensity) + (INT_W + 1)'(win_i[DELAY+1].intensity);
    lap     = (twice >= sides) ? twice - sides : sides - twice;
    lap_ext = CONTRAST_W'(lap);

    cls = LANE_NONE;
    if (meta_i.inr && (win_i[DELAY].intensity == cfg_i.lane_int)) begin
      if (lap_ext == cfg_i.lane_contrast) begin
        cls = LANE_CORNER;
      end else if (lap_ext == '0) begin
        cls = LANE_SURFACE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (adv_a) a_valid_q <= cap_valid_i;
      if (adv_b) b_valid_q <= a_valid_q;
      if (adv_c) c_valid_q <= b_valid_q;
    end
  end

  always_comb begin
    sq     = SQ_W'(b_mag_q) * SQ_W'(b_mag_q);
    sq_ext = EXT_W'(sq);
    curv   = (sq_ext > EXT_W'({CURV_W{1'b1}})) ? {CURV_W{1'b1}} : CURV_W'(sq_ext);
  end

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      a_nsum_q <= meta_i.inr ? nsum : '0;
      a_csum_q <= meta_i.inr ? csum : '0;
      a_meta_q <= meta_i;
      a_rej_q  <= win_i[DELAY].rej;
      a_cls_q  <= cls;
    end
    if (adv_b) begin
      b_mag_q  <= (a_nsum_q >= a_csum_q) ? a_nsum_q - a_csum_q : a_csum_q - a_nsum_q;
      b_meta_q <= a_meta_q;
      b_rej_q  <= a_rej_q;
      b_cls_q  <= a_cls_q;
    end
    if (adv_c) begin
      c_curv_q <= curv;
      c_meta_q <= b_meta_q;
      c_rej_q  <= b_rej_q;
      c_cls_q  <= b_cls_q;
    end
  end

  assign result_o.valid       = c_valid_q;
  assign result_o.point_index = IDX_W'(c_meta_q.idx);
  assign result_o.curvature   = c_curv_q;
  assign result_o.rejected    = c_rej_q;
  assign result_o.lane_class  = c_cls_q;
  assign result_o.in_range    = c_meta_q.inr;
  assign result_o.last_out    = c_meta_q.last;

endmodule

// ===== design/lidar_curvature_occlusion_marker_unit.sv =====
// Top level of the lidar curvature and occlusion marker: cell chain, control and APB registers.
`timescale 1ns / 1ps

// Channel    Dir  Handshake              Transaction
// point_i    in   valid/ready            one lidar point (range, column, intensity, end flag)
// result_o   out  valid/ready            one point result (index, curvature, flags, class)
// APB        in   psel/penable/pready    register write or read, pready tied high
//
// Sustained rate is one point per cycle. A point's result is captured from cell DELAY
// when the point HALF_WINDOW+1 places later arrives, then passes two register stages
// (window sums, magnitude) to the output register, which takes the square.
// The last point of a cloud starts a drain: the chain shifts once a cycle and each
// pending point is captured as it reaches cell DELAY; point_i.ready is low for the drain.
// A stalled result holds the whole pipe and then the chain.
// Reset clears control state, the cells and the registers to their reset values.

module lidar_curvature_occlusion_marker_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lcom_point_if.sink                        point_i,
  lcom_result_if.source                     result_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lcom_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lcom_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lcom_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import lcom_pkg::*;

  // ---------------------------------------------------------------------------
  // APB register file
  // ---------------------------------------------------------------------------
  cfg_t     cfg_q, cfg_d;
  cfg_reg_e reg_sel;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[APB_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_sel)
        REG_OCC_DEPTH:     cfg_d.occ_depth     = pwdata[OCC_W-1:0];
        REG_COL_GAP:       cfg_d.col_gap       = pwdata[GAP_W-1:0];
        REG_BEAM_RATIO:    cfg_d.beam_ratio    = pwdata[RATIO_W-1:0];
        REG_LANE_INT:      cfg_d.lane_int      = pwdata[LANE_W-1:0];
        REG_LANE_CONTRAST: cfg_d.lane_contrast = pwdata[CONTRAST_W-1:0];
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_OCC_DEPTH:     prdata = APB_DATA_W'(cfg_q.occ_depth);
      REG_COL_GAP:       prdata = APB_DATA_W'(cfg_q.col_gap);
      REG_BEAM_RATIO:    prdata = APB_DATA_W'(cfg_q.beam_ratio);
      REG_LANE_INT:      prdata = APB_DATA_W'(cfg_q.lane_int);
      REG_LANE_CONTRAST: prdata = APB_DATA_W'(cfg_q.lane_contrast);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.occ_depth     <= OCC_RST;
      cfg_q.col_gap       <= GAP_RST;
      cfg_q.beam_ratio    <= RATIO_RST;
      cfg_q.lane_int      <= LANE_RST;
      cfg_q.lane_contrast <= CONTRAST_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  n_q, n_d;          // points taken in this cloud
  logic [CNT_W-1:0]  idx_q, idx_d;      // index of the point in cell DELAY
  logic [SLOT_W-1:0] slot_q, slot_d;    // its slot in the post-arrival window
  logic [SLOT_W-1:0] top_q, top_d;      // oldest slot that still owes a result
  logic [FAR_W-1:0]  far_cnt_q, far_cnt_d;
  logic              pend_q, pend_d;    // cell DELAY holds a result to capture

  logic  point_ready;
  logic  drain_step;
  logic  acc;
  logic  last_pt;
  logic  win_free;
  logic  cap_ready;
  logic  shift;
  mark_t marks;
  meta_t meta;

  assign win_free = !pend_q || cap_ready;
  assign acc      = point_i.valid && point_ready;
  assign last_pt  = point_i.end_of_cloud || (n_q == CNT_W'(MAX_POINTS - 1));
  assign shift    = acc || (drain_step && (slot_q != '0));

  always_comb begin : fsm_next
    state_d = state_q;
    case (state_q)
      ST_RUN:   if (acc && last_pt) state_d = ST_DRAIN;
      ST_DRAIN: if (drain_step && (slot_q == '0)) state_d = ST_RUN;
      default:  state_d = ST_RUN;
    endcase
  end

  always_comb begin : fsm_out
    point_ready = 1'b0;
    drain_step  = 1'b0;
    case (state_q)
      ST_RUN:   point_ready = win_free;
      ST_DRAIN: drain_step  = win_free;
      default: ;
    endcase
  end

  assign point_i.ready = point_ready;

  always_comb begin
    n_d       = n_q;
    idx_d     = idx_q;
    slot_d    = slot_q;
    top_d     = top_q;
    far_cnt_d = far_cnt_q;
    pend_d    = pend_q && !cap_ready;

    if (acc) begin
      idx_d  = CNT_W'(n_q - CNT_W'(DELAY));
      slot_d = SLOT_W'(DELAY);
      pend_d = n_q >= CNT_W'(DELAY);
      top_d  = (n_q >= CNT_W'(DELAY)) ? SLOT_W'(DELAY) : SLOT_W'(n_q);
      if (last_pt) begin
        n_d       = '0;
        far_cnt_d = '0;
      end else begin
        n_d = n_q + 1'b1;
        // a far-side edge marks this point and the next HALF_WINDOW
        if (marks.far) begin
          far_cnt_d = FAR_W'(HALF_WINDOW);
        end else if (far_cnt_q != '0) begin
          far_cnt_d = far_cnt_q - 1'b1;
        end
      end
    end else if (drain_step && (slot_q != '0)) begin
      slot_d = slot_q - 1'b1;
      idx_d  = idx_q + 1'b1;
      pend_d = (slot_q - 1'b1) <= top_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_RUN;
      n_q       <= '0;
      idx_q     <= '0;
      slot_q    <= '0;
      top_q     <= '0;
      far_cnt_q <= '0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      idx_q     <= idx_d;
      slot_q    <= slot_d;
      top_q     <= top_d;
      far_cnt_q <= far_cnt_d;
      pend_q    <= pend_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain: cell 0 takes the new point, cell j the old content of cell j-1
  // ---------------------------------------------------------------------------
  slot_t          win [WIN];
  slot_t          up  [WIN];
  slot_t          new_slot;
  logic [WIN-1:0] mark;

  lcom_edge u_edge (
    .en_i        (n_q >= CNT_W'(DELAY)),
    .prev_i      (win[0]),
    .prev2_i     (win[1]),
    .new_range_i (point_i.range_mm),
    .new_col_i   (point_i.column),
    .cfg_i       (cfg_q),
    .mark_o      (marks)
  );

  always_comb begin
    if (state_q == ST_DRAIN) begin
      new_slot = '0;  // flush fill
    end else begin
      new_slot.range_mm  = point_i.range_mm;
      new_slot.column    = point_i.column;
      new_slot.intensity = point_i.intensity_tenths;
      new_slot.rej       = marks.far || (far_cnt_q != '0);
    end

    up[0] = new_slot;
    for (int j = 1; j < WIN; j++) begin
      up[j] = win[j-1];
    end

    // near-side edge marks the previous point and HALF_WINDOW before it;
    // a parallel beam marks the previous point alone
    mark = '0;
    if (acc) begin
      for (int j = 1; j <= DELAY; j++) begin
        mark[j] = marks.near;
      end
      mark[1] = marks.near || marks.par;
    end
  end

  for (genvar j = 0; j < WIN; j++) begin : g_cell
    lcom_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .mark_i  (mark[j]),
      .up_i    (up[j]),
      .slot_o  (win[j])
    );
  end

  // ---------------------------------------------------------------------------
  // Result pipe
  // ---------------------------------------------------------------------------
  assign meta.idx  = idx_q;
  assign meta.inr  = (slot_q >= SLOT_W'(HALF_WINDOW)) && (idx_q >= CNT_W'(HALF_WINDOW));
  assign meta.last = (state_q == ST_DRAIN) && (slot_q == '0);

  lcom_result_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_valid_i (pend_q),
    .cap_ready_o (cap_ready),
    .win_i       (win),
    .meta_i      (meta),
    .cfg_i       (cfg_q),
    .result_o    (result_o)
  );

endmodule
